@@ src/dsg_pkg.sv @@
// shared types, constants and helpers of the dose step generator
// no dependencies; imported by dsg_chan_step and the core
package dsg_pkg;

    localparam int CHANNELS = 16;
    localparam int CH_W     = (CHANNELS > 1) ? $clog2(CHANNELS) : 1;
    localparam int CNT_W    = $clog2(CHANNELS + 1);
    localparam int VEC_W    = (CHANNELS > 16) ? CHANNELS : 16;

    localparam logic OP_TICK  = 1'b0;
    localparam logic OP_START = 1'b1;

    localparam logic [1:0] REG_PULSES_ML      = 2'd0;
    localparam logic [1:0] REG_PULSES_TENTH   = 2'd1;
    localparam logic [1:0] REG_PULSES_HUNDRED = 2'd2;
    localparam logic [1:0] REG_SLOW_DIVIDER   = 2'd3;

    localparam logic [15:0] PULSES_ML_RESET      = 16'd322;
    localparam logic [15:0] PULSES_TENTH_RESET   = 16'd33;
    localparam logic [15:0] PULSES_HUNDRED_RESET = 16'd10;
    localparam logic [2:0]  SLOW_DIVIDER_RESET   = 3'd5;

    // x / 100 = ((x >> 2) * 41944) >> 20 and x / 10 = (x * 103) >> 10 over the ranges used
    localparam logic [15:0] RECIP_100 = 16'd41944;
    localparam logic [15:0] RECIP_10  = 16'd103;
    localparam logic [15:0] CONST_100 = 16'd100;
    localparam logic [15:0] CONST_10  = 16'd10;

    typedef enum logic [3:0] {
        S_IDLE,
        S_SPLIT_HI,
        S_SPLIT_BACK,
        S_SPLIT_REM,
        S_SPLIT_TEN,
        S_MUL_WHOLE,
        S_MUL_TENTH,
        S_MUL_HUND,
        S_SUM,
        S_LOAD,
        S_TICK,
        S_RESULT
    } state_t;

    typedef struct packed {
        logic [15:0] period_left;
        logic [15:0] period_setting;
        logic [31:0] fast_left;
        logic [31:0] slow_left;
        logic [2:0]  slow_wait;
    } chan_rec_t;

    localparam int REC_W = $bits(chan_rec_t);

    typedef struct packed {
        logic toggle;
        logic stop;
    } step_ctl_t;

    function automatic logic [15:0] low16(input logic [CHANNELS-1:0] v);
        logic [VEC_W-1:0] w;
        w = VEC_W'(v);
        return w[15:0];
    endfunction

endpackage

@@ src/dsg_ram.sv @@
// generic single write port ram with registered read
// no dependencies
module dsg_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16
) (
    input  logic                                         clk,
    input  logic                                         wr_en,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] wr_addr,
    input  logic [WIDTH-1:0]                             wr_data,
    input  logic [((DEPTH > 1) ? $clog2(DEPTH) : 1)-1:0] rd_addr,
    output logic [WIDTH-1:0]                             rd_data
);

    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            mem[wr_addr] <= wr_data;
        end
        rd_data <= mem[rd_addr];
    end

endmodule

@@ src/dsg_mul.sv @@
// shared 16 x 16 multiplier with registered product
// depends on nothing but the operands chosen by the sequencer
module dsg_mul (
    input  logic        clk,
    input  logic [15:0] a,
    input  logic [15:0] b,
    output logic [31:0] prod
);

    always_ff @(posedge clk)
    begin
        prod <= a * b;
    end

endmodule

@@ src/dsg_chan_step.sv @@
// one tick of one channel record: period count, fast and slow phase, stop
// depends on dsg_pkg
module dsg_chan_step (
    input  dsg_pkg::chan_rec_t rec,
    input  logic [2:0]         slow_divider,
    output dsg_pkg::chan_rec_t rec_next,
    output dsg_pkg::step_ctl_t ctl
);

    import dsg_pkg::*;

    always_comb
    begin
        rec_next   = rec;
        ctl.toggle = 1'b0;
        ctl.stop   = 1'b0;
        if (rec.period_left != 16'd0)
        begin
            rec_next.period_left = rec.period_left - 16'd1;
        end
        else
        begin
            rec_next.period_left = rec.period_setting;
            if (rec.fast_left != 32'd0)
            begin
                rec_next.fast_left = rec.fast_left - 32'd1;
                ctl.toggle         = 1'b1;
            end
            else if (rec.slow_left != 32'd0)
            begin
                if (rec.slow_wait < slow_divider)
                begin
                    rec_next.slow_wait = rec.slow_wait + 3'd1;
                end
                else
                begin
                    rec_next.slow_wait = 3'd0;
                    rec_next.slow_left = rec.slow_left - 32'd1;
                    ctl.toggle         = 1'b1;
                end
            end
            else
            begin
                ctl.stop = 1'b1;
            end
        end
    end

endmodule

@@ src/multi_channel_dose_step_generator_core.sv @@
// start item: split, multiply, sum and load states, then the result state (shared multiplier, 7 products)
// tick item: a sweep over all CHANNELS records before the result state, one channel record
// per cycle through the record ram read and write ports
// one item at a time; the next item is taken once the result sits in the output register
// reset: all channels idle with motors disabled, step and direction low, registers at
// defaults; the record ram is not cleared, a start loads every field it uses
module multi_channel_dose_step_generator_core (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        item_valid,
    output logic        item_stall,
    input  logic        operation,
    input  logic [3:0]  channel,
    input  logic [15:0] volume_hundredths,
    input  logic [15:0] step_period,
    input  logic        pump_direction,
    output logic        result_valid,
    input  logic        result_stall,
    output logic [15:0] step_lines,
    output logic [15:0] motors_disabled,
    output logic [15:0] direction_lines,
    output logic [15:0] channels_busy,
    output logic [15:0] channels_finished,
    input  logic        cfg_valid,
    output logic        cfg_ready,
    input  logic [1:0]  cfg_index,
    input  logic [15:0] cfg_data
);

    import dsg_pkg::*;

    state_t state_reg, state_next;

    logic [15:0] ppm_reg, pptm_reg, pphm_reg;
    logic [2:0]  div_reg;

    logic [15:0] vol_reg, vol_next;
    logic [15:0] period_reg, period_next;
    logic        pdir_reg, pdir_next;
    logic [3:0]  chan_reg, chan_next;

    logic [9:0]  whole_reg, whole_next;
    logic [6:0]  rem_reg, rem_next;
    logic [3:0]  tenth_reg, tenth_next;
    logic [3:0]  hund_reg, hund_next;
    logic [31:0] fast_reg, fast_next;
    logic [31:0] slow_reg, slow_next;

    logic [CNT_W-1:0] tick_cnt_reg, tick_cnt_next;
    logic [CNT_W-1:0] tick_prev;
    logic [CH_W-1:0]  proc_addr;
    logic [CH_W-1:0]  chan_addr;
    logic             chan_ok;

    logic [CHANNELS-1:0] running_reg, running_next;
    logic [CHANNELS-1:0] step_reg, step_next;
    logic [CHANNELS-1:0] dirs_reg, dirs_next;
    logic [CHANNELS-1:0] dis_reg, dis_next;
    logic [CHANNELS-1:0] fin_reg, fin_next;

    logic        result_valid_reg, result_valid_next;
    logic [15:0] out_step_reg, out_step_next;
    logic [15:0] out_dis_reg, out_dis_next;
    logic [15:0] out_dir_reg, out_dir_next;
    logic [15:0] out_busy_reg, out_busy_next;
    logic [15:0] out_fin_reg, out_fin_next;

    logic [15:0] mul_a, mul_b;
    logic [31:0] prod;
    logic [15:0] rem_calc;
    logic [6:0]  hund_calc;
    logic [31:0] fast_tot, slow_tot;

    logic            ram_we;
    logic [CH_W-1:0] ram_wr_addr;
    chan_rec_t       ram_wr_data;
    chan_rec_t       ram_rd_data;
    chan_rec_t       upd_rec;
    step_ctl_t       upd_ctl;

    dsg_mul u_mul (
        .clk  (clk),
        .a    (mul_a),
        .b    (mul_b),
        .prod (prod)
    );

    dsg_ram #(
        .WIDTH (REC_W),
        .DEPTH (CHANNELS)
    ) u_rec_ram (
        .clk     (clk),
        .wr_en   (ram_we),
        .wr_addr (ram_wr_addr),
        .wr_data (ram_wr_data),
        .rd_addr (tick_cnt_reg[CH_W-1:0]),
        .rd_data (ram_rd_data)
    );

    dsg_chan_step u_step (
        .rec          (ram_rd_data),
        .slow_divider (div_reg),
        .rec_next     (upd_rec),
        .ctl          (upd_ctl)
    );

    assign item_stall        = (state_reg != S_IDLE);
    assign cfg_ready         = 1'b1;
    assign result_valid      = result_valid_reg;
    assign step_lines        = out_step_reg;
    assign motors_disabled   = out_dis_reg;
    assign direction_lines   = out_dir_reg;
    assign channels_busy     = out_busy_reg;
    assign channels_finished = out_fin_reg;

    assign tick_prev = tick_cnt_reg - CNT_W'(1);
    assign proc_addr = tick_prev[CH_W-1:0];
    assign chan_addr = CH_W'(chan_reg);
    assign chan_ok   = (32'(chan_reg) < CHANNELS);
    assign rem_calc  = vol_reg - prod[15:0];
    assign hund_calc = rem_reg - prod[6:0];
    assign fast_tot  = {fast_reg[30:0], 1'b0};
    assign slow_tot  = {slow_reg[30:0], 1'b0};

    // next state
    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    state_next = (operation == OP_START) ? S_SPLIT_HI : S_TICK;
                end
            end
            S_SPLIT_HI:   state_next = S_SPLIT_BACK;
            S_SPLIT_BACK: state_next = S_SPLIT_REM;
            S_SPLIT_REM:  state_next = S_SPLIT_TEN;
            S_SPLIT_TEN:  state_next = S_MUL_WHOLE;
            S_MUL_WHOLE:  state_next = S_MUL_TENTH;
            S_MUL_TENTH:  state_next = S_MUL_HUND;
            S_MUL_HUND:   state_next = S_SUM;
            S_SUM:        state_next = S_LOAD;
            S_LOAD:       state_next = S_RESULT;
            S_TICK:
            begin
                if (tick_cnt_reg == CNT_W'(CHANNELS))
                begin
                    state_next = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    state_next = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    // datapath and outputs
    always_comb
    begin
        vol_next          = vol_reg;
        period_next       = period_reg;
        pdir_next         = pdir_reg;
        chan_next         = chan_reg;
        whole_next        = whole_reg;
        rem_next          = rem_reg;
        tenth_next        = tenth_reg;
        hund_next         = hund_reg;
        fast_next         = fast_reg;
        slow_next         = slow_reg;
        tick_cnt_next     = tick_cnt_reg;
        running_next      = running_reg;
        step_next         = step_reg;
        dirs_next         = dirs_reg;
        dis_next          = dis_reg;
        fin_next          = fin_reg;
        out_step_next     = out_step_reg;
        out_dis_next      = out_dis_reg;
        out_dir_next      = out_dir_reg;
        out_busy_next     = out_busy_reg;
        out_fin_next      = out_fin_reg;
        result_valid_next = result_valid_reg && result_stall;
        mul_a             = 16'd0;
        mul_b             = 16'd0;
        ram_we            = 1'b0;
        ram_wr_addr       = proc_addr;
        ram_wr_data       = upd_rec;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    vol_next      = volume_hundredths;
                    period_next   = step_period;
                    pdir_next     = pump_direction;
                    chan_next     = channel;
                    tick_cnt_next = '0;
                    fin_next      = '0;
                end
            end
            S_SPLIT_HI:
            begin
                mul_a = {2'b00, vol_reg[15:2]};
                mul_b = RECIP_100;
            end
            S_SPLIT_BACK:
            begin
                whole_next = prod[29:20];
                mul_a      = 16'(prod[29:20]);
                mul_b      = CONST_100;
            end
            S_SPLIT_REM:
            begin
                rem_next = rem_calc[6:0];
                mul_a    = 16'(rem_calc[6:0]);
                mul_b    = RECIP_10;
            end
            S_SPLIT_TEN:
            begin
                tenth_next = prod[13:10];
                mul_a      = 16'(prod[13:10]);
                mul_b      = CONST_10;
            end
            S_MUL_WHOLE:
            begin
                hund_next = hund_calc[3:0];
                mul_a     = 16'(whole_reg);
                mul_b     = ppm_reg;
            end
            S_MUL_TENTH:
            begin
                fast_next = prod;
                mul_a     = 16'(tenth_reg);
                mul_b     = pptm_reg;
            end
            S_MUL_HUND:
            begin
                slow_next = prod;
                mul_a     = 16'(hund_reg);
                mul_b     = pphm_reg;
            end
            S_SUM:
            begin
                slow_next = slow_reg + prod;
            end
            S_LOAD:
            begin
                ram_wr_addr                = chan_addr;
                ram_wr_data.period_left    = period_reg;
                ram_wr_data.period_setting = period_reg;
                ram_wr_data.slow_wait      = 3'd0;
                if (fast_tot != 32'd0)
                begin
                    ram_wr_data.fast_left = fast_tot + slow_tot;
                    ram_wr_data.slow_left = 32'd0;
                end
                else
                begin
                    ram_wr_data.fast_left = 32'd0;
                    ram_wr_data.slow_left = slow_tot;
                end
                if (chan_ok)
                begin
                    ram_we                  = 1'b1;
                    running_next[chan_addr] = 1'b1;
                    dis_next[chan_addr]     = 1'b0;
                    dirs_next[chan_addr]    = pdir_reg;
                end
            end
            S_TICK:
            begin
                if (tick_cnt_reg != CNT_W'(CHANNELS))
                begin
                    tick_cnt_next = tick_cnt_reg + CNT_W'(1);
                end
                if (tick_cnt_reg != '0 && running_reg[proc_addr])
                begin
                    ram_we = 1'b1;
                    if (upd_ctl.toggle)
                    begin
                        step_next[proc_addr] = ~step_reg[proc_addr];
                    end
                    if (upd_ctl.stop)
                    begin
                        running_next[proc_addr] = 1'b0;
                        step_next[proc_addr]    = 1'b0;
                        dis_next[proc_addr]     = 1'b1;
                        fin_next[proc_addr]     = 1'b1;
                    end
                end
            end
            S_RESULT:
            begin
                if (!result_valid_reg || !result_stall)
                begin
                    result_valid_next = 1'b1;
                    out_step_next     = low16(step_reg);
                    out_dis_next      = low16(dis_reg);
                    out_dir_next      = low16(dirs_reg);
                    out_busy_next     = low16(running_reg);
                    out_fin_next      = low16(fin_reg);
                end
            end
            default:
            begin
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg        <= S_IDLE;
            ppm_reg          <= PULSES_ML_RESET;
            pptm_reg         <= PULSES_TENTH_RESET;
            pphm_reg         <= PULSES_HUNDRED_RESET;
            div_reg          <= SLOW_DIVIDER_RESET;
            tick_cnt_reg     <= '0;
            running_reg      <= '0;
            step_reg         <= '0;
            dirs_reg         <= '0;
            dis_reg          <= '1;
            fin_reg          <= '0;
            result_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg        <= state_next;
            tick_cnt_reg     <= tick_cnt_next;
            running_reg      <= running_next;
            step_reg         <= step_next;
            dirs_reg         <= dirs_next;
            dis_reg          <= dis_next;
            fin_reg          <= fin_next;
            result_valid_reg <= result_valid_next;
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    REG_PULSES_ML:      ppm_reg  <= cfg_data;
                    REG_PULSES_TENTH:   pptm_reg <= cfg_data;
                    REG_PULSES_HUNDRED: pphm_reg <= cfg_data;
                    REG_SLOW_DIVIDER:   div_reg  <= cfg_data[2:0];
                    default:
                    begin
                    end
                endcase
            end
        end
    end

    always_ff @(posedge clk)
    begin
        vol_reg      <= vol_next;
        period_reg   <= period_next;
        pdir_reg     <= pdir_next;
        chan_reg     <= chan_next;
        whole_reg    <= whole_next;
        rem_reg      <= rem_next;
        tenth_reg    <= tenth_next;
        hund_reg     <= hund_next;
        fast_reg     <= fast_next;
        slow_reg     <= slow_next;
        out_step_reg <= out_step_next;
        out_dis_reg  <= out_dis_next;
        out_dir_reg  <= out_dir_next;
        out_busy_reg <= out_busy_next;
        out_fin_reg  <= out_fin_next;
    end

    assert property (@(posedge clk) disable iff (!rst_n)
        (running_reg & dis_reg) == '0)
        else $error("channel running with motor disabled");

    assert property (@(posedge clk) disable iff (!rst_n)
        (dis_reg & step_reg) == '0)
        else $error("step line high on a disabled channel");

    assert property (@(posedge clk) disable iff (!rst_n)
        (state_reg == S_TICK) |-> (tick_cnt_reg <= CNT_W'(CHANNELS)))
        else $error("tick sweep ran past the last channel");

endmodule

@@ tb/sv/tb.sv @@
`timescale 1ns / 1ps
// testbench for multi_channel_dose_step_generator_core: queue-fed driver, checking monitor
// and an in-line channel predictor; depends on dsg_pkg and the core only
module tb;
    import dsg_pkg::*;

    localparam int NCH = dsg_pkg::CHANNELS;

    typedef struct packed {
        logic        op;
        logic [3:0]  chan;
        logic [15:0] volume;
        logic [15:0] period;
        logic        dir;
    } dose_item_t;

    typedef struct packed {
        logic [15:0] steps;
        logic [15:0] disabled;
        logic [15:0] dirs;
        logic [15:0] busy;
        logic [15:0] finished;
    } line_state_t;

    logic        clk;
    logic        rst_n = 1'b0;
    logic        item_valid = 1'b0;
    logic        item_stall;
    logic        operation = OP_TICK;
    logic [3:0]  channel = 4'd0;
    logic [15:0] volume_hundredths = 16'd0;
    logic [15:0] step_period = 16'd0;
    logic        pump_direction = 1'b0;
    logic        result_valid;
    logic        result_stall = 1'b0;
    logic [15:0] step_lines;
    logic [15:0] motors_disabled;
    logic [15:0] direction_lines;
    logic [15:0] channels_busy;
    logic [15:0] channels_finished;
    logic        cfg_valid = 1'b0;
    logic        cfg_ready;
    logic [1:0]  cfg_index = REG_PULSES_ML;
    logic [15:0] cfg_data = 16'd0;

    dose_item_t  pending_items[$];
    line_state_t expected_lines[$];
    dose_item_t  offered;
    line_state_t want;
    int unsigned error_count = 0;
    int unsigned sender_idle_pct = 0;
    int unsigned receiver_stall_pct = 0;
    logic        hold_off = 1'b0;

    // predicted channel state and register copies
    logic        ch_running   [NCH];
    logic [15:0] ch_count     [NCH];
    logic [15:0] ch_period    [NCH];
    logic [31:0] ch_fast_goal [NCH];
    logic [31:0] ch_fast_made [NCH];
    logic [31:0] ch_slow_goal [NCH];
    logic [31:0] ch_slow_made [NCH];
    logic [2:0]  ch_slow_skip [NCH];
    logic        ch_step      [NCH];
    logic        ch_dir       [NCH];
    logic        ch_off       [NCH];
    logic [15:0] cfg_ml;
    logic [15:0] cfg_tenth;
    logic [15:0] cfg_hund;
    logic [2:0]  cfg_div;

    multi_channel_dose_step_generator_core dut (
        .clk               (clk),
        .rst_n             (rst_n),
        .item_valid        (item_valid),
        .item_stall        (item_stall),
        .operation         (operation),
        .channel           (channel),
        .volume_hundredths (volume_hundredths),
        .step_period       (step_period),
        .pump_direction    (pump_direction),
        .result_valid      (result_valid),
        .result_stall      (result_stall),
        .step_lines        (step_lines),
        .motors_disabled   (motors_disabled),
        .direction_lines   (direction_lines),
        .channels_busy     (channels_busy),
        .channels_finished (channels_finished),
        .cfg_valid         (cfg_valid),
        .cfg_ready         (cfg_ready),
        .cfg_index         (cfg_index),
        .cfg_data          (cfg_data)
    );

    function automatic void reset_channels();
        cfg_ml    = PULSES_ML_RESET;
        cfg_tenth = PULSES_TENTH_RESET;
        cfg_hund  = PULSES_HUNDRED_RESET;
        cfg_div   = SLOW_DIVIDER_RESET;
        for (int c = 0; c < NCH; c++)
        begin
            ch_running[c]   = 1'b0;
            ch_count[c]     = '0;
            ch_period[c]    = '0;
            ch_fast_goal[c] = '0;
            ch_fast_made[c] = '0;
            ch_slow_goal[c] = '0;
            ch_slow_made[c] = '0;
            ch_slow_skip[c] = '0;
            ch_step[c]      = 1'b0;
            ch_dir[c]       = 1'b0;
            ch_off[c]       = 1'b1;
        end
    endfunction

    function automatic line_state_t apply_dose_item(input dose_item_t it);
        line_state_t r;
        logic [31:0] whole;
        logic [31:0] tenth;
        logic [31:0] hund;
        logic [31:0] fast;
        logic [31:0] slow;
        int          ch;
        r = '0;
        ch = int'(it.chan);
        if (it.op == OP_START)
        begin
            if (ch < NCH)
            begin
                whole = 32'(it.volume) / 100;
                tenth = (32'(it.volume) / 10) % 10;
                hund  = 32'(it.volume) % 10;
                fast  = whole * 32'(cfg_ml) * 2;
                slow  = (tenth * 32'(cfg_tenth) + hund * 32'(cfg_hund)) * 2;
                if (fast != 0)
                begin
                    fast = fast + slow;
                    slow = 0;
                end
                ch_fast_goal[ch] = fast;
                ch_slow_goal[ch] = slow;
                ch_fast_made[ch] = '0;
                ch_slow_made[ch] = '0;
                ch_slow_skip[ch] = '0;
                ch_count[ch]     = '0;
                ch_period[ch]    = it.period;
                ch_dir[ch]       = it.dir;
                ch_off[ch]       = 1'b0;
                ch_running[ch]   = 1'b1;
            end
        end
        else
        begin
            for (int c = 0; c < NCH; c++)
            begin
                if (ch_running[c])
                begin
                    if (32'(ch_count[c]) + 1 <= 32'(ch_period[c]))
                        ch_count[c] = ch_count[c] + 16'd1;
                    else
                    begin
                        ch_count[c] = '0;
                        if (ch_fast_made[c] < ch_fast_goal[c])
                        begin
                            ch_fast_made[c] = ch_fast_made[c] + 1;
                            ch_step[c] = ~ch_step[c];
                        end
                        else if (ch_slow_made[c] < ch_slow_goal[c])
                        begin
                            if (ch_slow_skip[c] < cfg_div)
                                ch_slow_skip[c] = ch_slow_skip[c] + 3'd1;
                            else
                            begin
                                ch_slow_skip[c] = '0;
                                ch_slow_made[c] = ch_slow_made[c] + 1;
                                ch_step[c] = ~ch_step[c];
                            end
                        end
                        else
                        begin
                            ch_running[c] = 1'b0;
                            ch_step[c]    = 1'b0;
                            ch_off[c]     = 1'b1;
                            if (c < 16)
                                r.finished[c] = 1'b1;
                        end
                    end
                end
            end
        end
        for (int c = 0; c < NCH && c < 16; c++)
        begin
            r.steps[c]    = ch_step[c];
            r.disabled[c] = ch_off[c];
            r.dirs[c]     = ch_dir[c];
            r.busy[c]     = ch_running[c];
        end
        return r;
    endfunction

    function automatic dose_item_t random_item();
        dose_item_t  it;
        int unsigned pick;
        it.op   = ($urandom_range(99) < 22) ? OP_START : OP_TICK;
        it.chan = 4'($urandom_range(15));
        pick = $urandom_range(99);
        if (pick < 80)
            it.volume = 16'($urandom_range(350));
        else if (pick < 90)
            it.volume = 16'($urandom_range(1000));
        else
            it.volume = 16'($urandom);
        pick = $urandom_range(99);
        if (pick < 70)
            it.period = 16'($urandom_range(3));
        else if (pick < 92)
            it.period = 16'($urandom_range(20));
        else
            it.period = 16'($urandom);
        it.dir = 1'($urandom_range(1));
        return it;
    endfunction

    function automatic void check_field(input string field, input logic [15:0] want_v,
                                        input logic [15:0] got_v);
        if (want_v !== got_v)
        begin
            $error("%s: expected %h, got %h", field, want_v, got_v);
            error_count++;
        end
    endfunction

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // item driver
    always @(posedge clk)
    begin
        if (!rst_n)
            item_valid <= 1'b0;
        else
        begin
            if (item_valid && !item_stall)
                expected_lines.push_back(apply_dose_item(offered));
            if (!item_valid || !item_stall)
            begin
                if (pending_items.size() > 0 && $urandom_range(99) >= sender_idle_pct)
                begin
                    offered = pending_items.pop_front();
                    item_valid        <= 1'b1;
                    operation         <= offered.op;
                    channel           <= offered.chan;
                    volume_hundredths <= offered.volume;
                    step_period       <= offered.period;
                    pump_direction    <= offered.dir;
                end
                else
                    item_valid <= 1'b0;
            end
        end
    end

    // result monitor
    always @(posedge clk)
    begin
        if (!rst_n)
            result_stall <= 1'b0;
        else
        begin
            if (result_valid && !result_stall)
            begin
                if (expected_lines.size() == 0)
                begin
                    $error("result transfer with no expectation pending");
                    error_count++;
                end
                else
                begin
                    want = expected_lines.pop_front();
                    check_field("step_lines", want.steps, step_lines);
                    check_field("motors_disabled", want.disabled, motors_disabled);
                    check_field("direction_lines", want.dirs, direction_lines);
                    check_field("channels_busy", want.busy, channels_busy);
                    check_field("channels_finished", want.finished, channels_finished);
                end
            end
            result_stall <= hold_off || ($urandom_range(99) < receiver_stall_pct);
        end
    end

    task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
        @(posedge clk);
        cfg_valid <= 1'b1;
        cfg_index <= idx;
        cfg_data  <= val;
        do
            @(posedge clk);
        while (!cfg_ready);
        cfg_valid <= 1'b0;
        case (idx)
            REG_PULSES_ML:      cfg_ml    = val;
            REG_PULSES_TENTH:   cfg_tenth = val;
            REG_PULSES_HUNDRED: cfg_hund  = val;
            REG_SLOW_DIVIDER:   cfg_div   = val[2:0];
            default: ;
        endcase
    endtask

    task automatic set_pulse_config(input logic [15:0] ml, input logic [15:0] tenth,
                                    input logic [15:0] hund, input logic [2:0] div);
        write_reg(REG_PULSES_ML, ml);
        write_reg(REG_PULSES_TENTH, tenth);
        write_reg(REG_PULSES_HUNDRED, hund);
        write_reg(REG_SLOW_DIVIDER, {13'($urandom), div});
    endtask

    task automatic wait_for_idle();
        @(negedge clk);
        while (pending_items.size() != 0 || item_valid || expected_lines.size() != 0)
            @(negedge clk);
        repeat (2 * NCH + 8) @(posedge clk);
    endtask

    task automatic push_start(input int ch, input int vol, input int per, input bit dir);
        dose_item_t it;
        it.op     = OP_START;
        it.chan   = 4'(ch);
        it.volume = 16'(vol);
        it.period = 16'(per);
        it.dir    = dir;
        pending_items.push_back(it);
    endtask

    task automatic push_ticks(input int n);
        dose_item_t it;
        repeat (n)
        begin
            it = random_item();
            it.op = OP_TICK;
            pending_items.push_back(it);
        end
    endtask

    task automatic run_random(input int n, input int idle_pct, input int stall_pct);
        @(negedge clk);
        sender_idle_pct    = idle_pct;
        receiver_stall_pct = stall_pct;
        repeat (n) pending_items.push_back(random_item());
        wait_for_idle();
    endtask

    initial
    begin
        reset_channels();
        repeat (6) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;

        // directed: zero volume, extreme fields, restarts, fast and slow doses
        push_ticks(1);
        push_start(0, 0, 0, 1'b1);
        push_ticks(1);
        push_start(15, 65535, 65535, 1'b1);
        push_start(7, 100, 1, 1'b0);
        push_start(8, 99, 0, 1'b1);
        push_ticks(4);
        push_start(7, 5, 0, 1'b1);
        push_start(15, 0, 65535, 1'b0);
        push_ticks(3);
        wait_for_idle();
        set_pulse_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd0);
        @(negedge clk);
        push_start(1, 65535, 0, 1'b1);
        push_start(2, 50, 0, 1'b0);
        push_ticks(3);
        wait_for_idle();
        set_pulse_config(16'd0, 16'd0, 16'd0, 3'd7);
        @(negedge clk);
        push_start(3, 999, 2, 1'b1);
        push_ticks(3);
        wait_for_idle();

        set_pulse_config(16'd1, 16'd1, 16'd1, 3'd0);
        run_random(250, 0, 0);
        set_pulse_config(16'd2, 16'd3, 16'd1, 3'd7);
        run_random(250, 71, 0);
        set_pulse_config(16'hFFFF, 16'hFFFF, 16'hFFFF, 3'd3);
        run_random(150, 0, 71);
        set_pulse_config(16'($urandom_range(3)), 16'($urandom_range(3)),
                         16'($urandom_range(3)), 3'($urandom_range(7)));
        run_random(250, 10, 10);

        // long receiver hold-off while items keep coming
        set_pulse_config(16'd1, 16'd1, 16'd1, 3'd2);
        @(posedge clk);
        hold_off <= 1'b1;
        @(negedge clk);
        sender_idle_pct    = 0;
        receiver_stall_pct = 0;
        repeat (200) pending_items.push_back(random_item());
        repeat (500) @(posedge clk);
        hold_off <= 1'b0;
        wait_for_idle();

        if (error_count == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

    initial
    begin
        #5_000_000;
        $display("TEST FAILED");
        $finish;
    end

endmodule

@@ multi_channel_dose_step_generator_core.f @@
src/dsg_pkg.sv
src/dsg_ram.sv
src/dsg_mul.sv
src/dsg_chan_step.sv
src/multi_channel_dose_step_generator_core.sv
tb/sv/tb.sv
